// ===== rtl/core/mfmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmc_pkg: shared types and constants of the max-flow / min-cut engine
// Field widths of the request and response beats, function and status codes,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package mfmc_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int CAP_BITS_DEF  = 16;

	localparam int FUNC_W     = 2;
	localparam int NODE_W     = 6;
	localparam int CAP_IN_W   = 16;
	localparam int STATUS_W   = 2;
	localparam int VALUE_W    = 22;
	localparam int NCOUNT_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [VALUE_W-1:0]  VALUE_MAX    = {VALUE_W{1'b1}};
	localparam logic [NODE_W-1:0]   SRC_RESET    = 6'd0;
	localparam logic [NODE_W-1:0]   SNK_RESET    = 6'd1;
	localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 7'd64;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD  = 2'd0,
		FN_RUN   = 2'd1,
		FN_QUERY = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_OVER_CAP = 2'd1,
		ST_CONSERVE = 2'd2,
		ST_NOT_RUN  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE = 2'd0,
		REG_SINK   = 2'd1,
		REG_NODES  = 2'd2
	} cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/core/mfmc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmc_if: request and response channels of the max-flow engine
// Valid/ready channels; a beat moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface mfmc_req_if;
	import mfmc_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [NODE_W-1:0]   tail_node;
	logic [NODE_W-1:0]   head_node;
	logic [CAP_IN_W-1:0] edge_capacity_in;
	logic [CAP_IN_W-1:0] edge_flow_in;

	modport source (output valid, func, tail_node, head_node, edge_capacity_in,
		edge_flow_in, input ready);
	modport sink (input valid, func, tail_node, head_node, edge_capacity_in,
		edge_flow_in, output ready);
endinterface

interface mfmc_rsp_if;
	import mfmc_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  value;
	logic                edge_exists;
	logic                in_cut;

	modport source (output valid, status, value, edge_exists, in_cut, input ready);
	modport sink (input valid, status, value, edge_exists, in_cut, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mfmc_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmc_matrix: adjacency-matrix store
// Residual capacity and original capacity with edge valid bit per node pair.
// Two registered read ports, one write port; separate write enables.
// ----------------------------------------------------------------------------
module mfmc_matrix #(
	parameter int AW       = 12,
	parameter int CAP_BITS = 16
) (
	input  logic                clk,
	input  logic [AW-1:0]       rd_a_addr,
	input  logic [AW-1:0]       rd_b_addr,
	input  logic                wr_res_en,
	input  logic                wr_cap_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [CAP_BITS-1:0] wr_res,
	input  logic [CAP_BITS-1:0] wr_cap,
	input  logic                wr_valid,
	output logic [CAP_BITS-1:0] rd_a_res,
	output logic [CAP_BITS-1:0] rd_a_cap,
	output logic                rd_a_valid,
	output logic [CAP_BITS-1:0] rd_b_res,
	output logic [CAP_BITS-1:0] rd_b_cap,
	output logic                rd_b_valid
);
	localparam int DEPTH = 1 << AW;

	logic [CAP_BITS-1:0] res_mem [DEPTH];
	logic [CAP_BITS:0]   cap_mem [DEPTH];

	// residual words
	always_ff @(posedge clk) begin
		if (wr_res_en) begin
			res_mem[wr_addr] <= wr_res;
		end
		rd_a_res <= res_mem[rd_a_addr];
		rd_b_res <= res_mem[rd_b_addr];
	end

	// original capacity with valid bit on top
	always_ff @(posedge clk) begin
		if (wr_cap_en) begin
			cap_mem[wr_addr] <= {wr_valid, wr_cap};
		end
		{rd_a_valid, rd_a_cap} <= cap_mem[rd_a_addr];
		{rd_b_valid, rd_b_cap} <= cap_mem[rd_b_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/max_flow_min_cut_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_flow_min_cut_engine: Edmonds-Karp max flow over an adjacency matrix
// Edge load, max-flow run, edge query with min-cut flag, and store clear.
// ----------------------------------------------------------------------------
// One request beat gives one response beat. A clear, and the clearing pass
// after reset, sweep the matrix store one word a cycle: MAX_NODES*MAX_NODES
// words (4096 by default), during which no request is taken. A run first
// checks flow conservation by reading every matrix pair through the two read
// ports, n*n pairs for n nodes in use; each breadth-first round then scans
// the row of each dequeued node, and each augmenting path rewrites the
// matrix over its single write port, a read-modify-write per path edge.
module max_flow_min_cut_engine #(
	parameter int MAX_NODES = mfmc_pkg::MAX_NODES_DEF,
	parameter int CAP_BITS  = mfmc_pkg::CAP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [mfmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mfmc_pkg::CFG_DATA_W-1:0]  cfg_data,
	mfmc_req_if.sink                         req,
	mfmc_rsp_if.source                       rsp
);
	import mfmc_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int WW = (CW > NCOUNT_W) ? CW : NCOUNT_W;
	localparam int AW = 2 * NW;
	localparam int FW = (CAP_BITS > CAP_IN_W) ? CAP_BITS : CAP_IN_W;
	localparam int QW = (CAP_BITS > VALUE_W) ? CAP_BITS : VALUE_W;
	localparam int BW = (CAP_BITS + NW + 2 > VALUE_W + 1) ? CAP_BITS + NW + 2 : VALUE_W + 1;

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_LOAD2, S_QUERY, S_BAL, S_BAL_CHK, S_BFS_INIT, S_DEQ,
		S_POP, S_LDB, S_SCAN, S_AUG_P, S_AUG_R, S_AUG_W1, S_AUG_W2, S_RUN_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [NODE_W-1:0]   src_q, snk_q;
	logic [NCOUNT_W-1:0] ncnt_q;

	// latched request and global status
	logic [NW-1:0]       x_q, y_q;
	logic [CAP_BITS-1:0] fin_q;
	logic                q_ok_q;
	status_t             err_q;
	logic                rej_q;
	logic [MAX_NODES-1:0] vis_q;
	logic [AW-1:0]       sweep_q;
	logic                clr_emit_q;

	// balance pass
	logic [NW-1:0]       k_q, j_q;
	logic                iss_done_q;
	logic                bal_v_s1, bal_first_s1, bal_last_s1;
	logic [NW-1:0]       bal_k_s1;
	logic signed [BW-1:0] acc_q, bal_s_q, bal_t_q, flow_q;
	logic                bad_q;

	// search and augment
	logic [CW-1:0]       head_q, tail_q;
	logic [NW-1:0]       i_q;
	logic [CAP_BITS-1:0] bi_q;
	logic                scan_v_s1, scan_last_s1;
	logic [NW-1:0]       scan_j_s1;
	logic [NW-1:0]       cur_q, prev_q;
	logic [CAP_BITS-1:0] aug_b_q, rb_q;

	// response register
	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [VALUE_W-1:0]  rsp_value_q;
	logic                rsp_exists_q, rsp_cut_q;

	// small node memories
	logic [NW-1:0]       q_mem   [MAX_NODES];
	logic [CAP_BITS-1:0] bn_mem  [MAX_NODES];
	logic [NW-1:0]       par_mem [MAX_NODES];
	logic [NW-1:0]       q_rd, par_rd;
	logic [CAP_BITS-1:0] bn_rd;
	logic                q_we, bn_we, par_we;
	logic [NW-1:0]       q_waddr, q_wdata, bn_waddr;
	logic [CAP_BITS-1:0] bn_wdata;

	// matrix ports
	logic [AW-1:0]       rd_a_addr, rd_b_addr, wr_addr;
	logic                wr_res_en, wr_cap_en, wr_valid;
	logic [CAP_BITS-1:0] wr_res, wr_cap;
	logic [CAP_BITS-1:0] rd_a_res, rd_a_cap, rd_b_res, rd_b_cap;
	logic                rd_a_valid, rd_b_valid;

	// decoded request and derived values
	logic [WW-1:0]       ncnt_w, n_w, nm1_w, x_w, y_w, s_w, t_w;
	logic [NW-1:0]       x_i, y_i, s_i, t_i;
	logic [FW-1:0]       cap_f, fin_f;
	logic [CAP_BITS-1:0] cap_in, fin_in;
	logic                accept, ld_ok, ld_over, q_ok, s_ok, j_last, k_last;
	logic [CAP_BITS-1:0] fa, fb, qf, nb;
	logic [QW-1:0]       qf_w;
	logic signed [BW-1:0] acc_n;
	logic                hit, found, bal_fail;
	logic                emit, em_exists, em_cut;
	status_t             em_status;
	logic [VALUE_W-1:0]  em_value;

	mfmc_matrix #(
		.AW       (AW),
		.CAP_BITS (CAP_BITS)
	) u_matrix (
		.clk        (clk),
		.rd_a_addr  (rd_a_addr),
		.rd_b_addr  (rd_b_addr),
		.wr_res_en  (wr_res_en),
		.wr_cap_en  (wr_cap_en),
		.wr_addr    (wr_addr),
		.wr_res     (wr_res),
		.wr_cap     (wr_cap),
		.wr_valid   (wr_valid),
		.rd_a_res   (rd_a_res),
		.rd_a_cap   (rd_a_cap),
		.rd_a_valid (rd_a_valid),
		.rd_b_res   (rd_b_res),
		.rd_b_cap   (rd_b_cap),
		.rd_b_valid (rd_b_valid)
	);

	assign req.ready       = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.value       = rsp_value_q;
	assign rsp.edge_exists = rsp_exists_q;
	assign rsp.in_cut      = rsp_cut_q;

	// index decoding and range checks
	always_comb begin
		accept  = req.valid && req.ready;
		ncnt_w  = WW'(ncnt_q);
		n_w     = (ncnt_w > WW'(MAX_NODES)) ? WW'(MAX_NODES) : ncnt_w;
		nm1_w   = n_w - WW'(1);
		x_w     = WW'(req.tail_node);
		y_w     = WW'(req.head_node);
		s_w     = WW'(src_q);
		t_w     = WW'(snk_q);
		x_i     = x_w[NW-1:0];
		y_i     = y_w[NW-1:0];
		s_i     = s_w[NW-1:0];
		t_i     = t_w[NW-1:0];
		cap_f   = FW'(req.edge_capacity_in);
		fin_f   = FW'(req.edge_flow_in);
		cap_in  = cap_f[CAP_BITS-1:0];
		fin_in  = fin_f[CAP_BITS-1:0];
		ld_ok   = (x_w < n_w) && (y_w < n_w) && (req.tail_node != req.head_node);
		ld_over = fin_in > cap_in;
		q_ok    = (x_w < WW'(MAX_NODES)) && (y_w < WW'(MAX_NODES));
		s_ok    = (s_w < n_w) && (t_w < n_w);
		j_last  = WW'(j_q) == nm1_w;
		k_last  = WW'(k_q) == nm1_w;
	end

	// balance accumulate, residual scan and query datapath
	always_comb begin
		fa       = rd_a_valid ? (rd_a_cap - rd_a_res) : '0;
		fb       = rd_b_valid ? (rd_b_cap - rd_b_res) : '0;
		acc_n    = (bal_first_s1 ? '0 : acc_q) + $signed(BW'(fb)) - $signed(BW'(fa));
		hit      = scan_v_s1 && !vis_q[scan_j_s1] && (rd_a_res != '0);
		nb       = (bi_q < rd_a_res) ? bi_q : rd_a_res;
		found    = hit && (scan_j_s1 == t_i);
		bal_fail = bad_q || (bal_s_q != -bal_t_q);
		qf       = rd_a_cap - rd_a_res;
		qf_w     = QW'(qf);
	end

	// response selection
	always_comb begin
		emit      = 1'b0;
		em_status = err_q;
		em_value  = '0;
		em_exists = 1'b0;
		em_cut    = 1'b0;
		case (state_q)
			S_SWEEP: begin
				if ((&sweep_q) && clr_emit_q) begin
					emit      = 1'b1;
					em_status = ST_NOT_RUN;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (req.func)
						FN_LOAD: begin
							if (!ld_ok) begin
								emit = 1'b1;
							end else if (ld_over) begin
								emit      = 1'b1;
								em_status = ST_OVER_CAP;
							end
						end
						FN_RUN: begin
							if (rej_q) begin
								emit      = 1'b1;
								em_status = ST_OVER_CAP;
							end else if (!s_ok) begin
								emit      = 1'b1;
								em_status = ST_CONSERVE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LOAD2: begin
				emit      = 1'b1;
				em_status = ST_NOT_RUN;
			end
			S_QUERY: begin
				emit      = 1'b1;
				em_exists = q_ok_q && rd_a_valid;
				if (q_ok_q && rd_a_valid) begin
					em_value = (qf_w > QW'(VALUE_MAX)) ? VALUE_MAX : qf_w[VALUE_W-1:0];
					em_cut   = (err_q == ST_OK) && vis_q[x_q] && !vis_q[y_q];
				end
			end
			S_BAL_CHK: begin
				if (bal_fail) begin
					emit      = 1'b1;
					em_status = ST_CONSERVE;
				end
			end
			S_RUN_DONE: begin
				emit      = 1'b1;
				em_status = ST_OK;
				if (flow_q < 0) begin
					em_value = '0;
				end else if (flow_q > $signed(BW'(VALUE_MAX))) begin
					em_value = VALUE_MAX;
				end else begin
					em_value = flow_q[VALUE_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// matrix addresses and writes
	always_comb begin
		rd_a_addr = {x_i, y_i};
		rd_b_addr = {y_i, x_i};
		wr_res_en = 1'b0;
		wr_cap_en = 1'b0;
		wr_addr   = {x_i, y_i};
		wr_res    = cap_in - fin_in;
		wr_cap    = cap_in;
		wr_valid  = 1'b1;
		case (state_q)
			S_SWEEP: begin
				wr_res_en = 1'b1;
				wr_cap_en = 1'b1;
				wr_addr   = sweep_q;
				wr_res    = '0;
				wr_cap    = '0;
				wr_valid  = 1'b0;
			end
			S_IDLE: begin
				if (accept && (req.func == FN_LOAD) && ld_ok && !ld_over) begin
					wr_res_en = 1'b1;
					wr_cap_en = 1'b1;
				end
			end
			S_LOAD2: begin
				wr_res_en = 1'b1;
				wr_cap_en = 1'b1;
				wr_addr   = {y_q, x_q};
				wr_res    = fin_q;
				wr_cap    = '0;
				wr_valid  = 1'b0;
			end
			S_BAL: begin
				rd_a_addr = {k_q, j_q};
				rd_b_addr = {j_q, k_q};
			end
			S_SCAN: begin
				rd_a_addr = {i_q, j_q};
			end
			S_AUG_R: begin
				rd_a_addr = {par_rd, cur_q};
				rd_b_addr = {cur_q, par_rd};
			end
			S_AUG_W1: begin
				wr_res_en = 1'b1;
				wr_addr   = {prev_q, cur_q};
				wr_res    = rd_a_res - aug_b_q;
			end
			S_AUG_W2: begin
				wr_res_en = 1'b1;
				wr_addr   = {cur_q, prev_q};
				wr_res    = rb_q + aug_b_q;
			end
			default: begin
			end
		endcase
	end

	// node memory writes
	always_comb begin
		q_we     = 1'b0;
		q_waddr  = tail_q[NW-1:0];
		q_wdata  = scan_j_s1;
		bn_we    = 1'b0;
		bn_waddr = scan_j_s1;
		bn_wdata = nb;
		par_we   = 1'b0;
		if (state_q == S_BFS_INIT) begin
			q_we     = 1'b1;
			q_waddr  = '0;
			q_wdata  = s_i;
			bn_we    = 1'b1;
			bn_waddr = s_i;
			bn_wdata = '1;
		end else if (state_q == S_SCAN && hit) begin
			q_we   = !found;
			bn_we  = 1'b1;
			par_we = 1'b1;
		end
	end

	// search queue, bottleneck and parent memories
	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		if (bn_we) begin
			bn_mem[bn_waddr] <= bn_wdata;
		end
		if (par_we) begin
			par_mem[scan_j_s1] <= i_q;
		end
		q_rd   <= q_mem[head_q[NW-1:0]];
		bn_rd  <= bn_mem[q_rd];
		par_rd <= par_mem[cur_q];
	end

	// control sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			src_q        <= SRC_RESET;
			snk_q        <= SNK_RESET;
			ncnt_q       <= NCOUNT_RESET;
			x_q          <= '0;
			y_q          <= '0;
			fin_q        <= '0;
			q_ok_q       <= 1'b0;
			err_q        <= ST_NOT_RUN;
			rej_q        <= 1'b0;
			vis_q        <= '0;
			sweep_q      <= '0;
			clr_emit_q   <= 1'b0;
			k_q          <= '0;
			j_q          <= '0;
			iss_done_q   <= 1'b0;
			bal_v_s1     <= 1'b0;
			bal_first_s1 <= 1'b0;
			bal_last_s1  <= 1'b0;
			bal_k_s1     <= '0;
			acc_q        <= '0;
			bal_s_q      <= '0;
			bal_t_q      <= '0;
			flow_q       <= '0;
			bad_q        <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			i_q          <= '0;
			bi_q         <= '0;
			scan_v_s1    <= 1'b0;
			scan_last_s1 <= 1'b0;
			scan_j_s1    <= '0;
			cur_q        <= '0;
			prev_q       <= '0;
			aug_b_q      <= '0;
			rb_q         <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_NOT_RUN;
			rsp_value_q  <= '0;
			rsp_exists_q <= 1'b0;
			rsp_cut_q    <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_write) begin
				case (cfg_index)
					REG_SOURCE: src_q  <= cfg_data[NODE_W-1:0];
					REG_SINK:   snk_q  <= cfg_data[NODE_W-1:0];
					REG_NODES:  ncnt_q <= cfg_data[NCOUNT_W-1:0];
					default: begin
					end
				endcase
			end

			// response beat
			if (emit) begin
				rsp_valid_q  <= 1'b1;
				rsp_status_q <= em_status;
				rsp_value_q  <= em_value;
				rsp_exists_q <= em_exists;
				rsp_cut_q    <= em_cut;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				// clearing pass over the matrix
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (&sweep_q) begin
						state_q <= S_IDLE;
					end
				end

				// take a request beat
				S_IDLE: begin
					if (accept) begin
						x_q    <= x_i;
						y_q    <= y_i;
						fin_q  <= fin_in;
						q_ok_q <= q_ok;
						case (req.func)
							FN_LOAD: begin
								if (ld_ok) begin
									err_q <= ST_NOT_RUN;
									if (ld_over) begin
										rej_q <= 1'b1;
									end else begin
										state_q <= S_LOAD2;
									end
								end
							end
							FN_RUN: begin
								vis_q <= '0;
								if (!rej_q && s_ok) begin
									k_q        <= '0;
									j_q        <= '0;
									iss_done_q <= 1'b0;
									bad_q      <= 1'b0;
									state_q    <= S_BAL;
								end else begin
									err_q <= rej_q ? ST_OVER_CAP : ST_CONSERVE;
								end
							end
							FN_QUERY: begin
								state_q <= S_QUERY;
							end
							default: begin
								vis_q      <= '0;
								err_q      <= ST_NOT_RUN;
								rej_q      <= 1'b0;
								sweep_q    <= '0;
								clr_emit_q <= 1'b1;
								state_q    <= S_SWEEP;
							end
						endcase
					end
				end

				S_LOAD2, S_QUERY: begin
					state_q <= S_IDLE;
				end

				// node balances: inflow minus outflow, one pair per cycle
				S_BAL: begin
					if (!iss_done_q) begin
						bal_v_s1     <= 1'b1;
						bal_k_s1     <= k_q;
						bal_first_s1 <= (j_q == '0);
						bal_last_s1  <= j_last;
						if (j_last) begin
							j_q <= '0;
							k_q <= k_q + 1'b1;
							if (k_last) begin
								iss_done_q <= 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						bal_v_s1 <= 1'b0;
					end
					if (bal_v_s1) begin
						acc_q <= acc_n;
						if (bal_last_s1) begin
							if (bal_k_s1 == s_i) begin
								bal_s_q <= acc_n;
							end
							if (bal_k_s1 == t_i) begin
								bal_t_q <= acc_n;
							end
							if (bal_k_s1 != s_i && bal_k_s1 != t_i && acc_n != '0) begin
								bad_q <= 1'b1;
							end
							if (WW'(bal_k_s1) == nm1_w) begin
								state_q <= S_BAL_CHK;
							end
						end
					end
				end

				S_BAL_CHK: begin
					if (bal_fail) begin
						err_q   <= ST_CONSERVE;
						state_q <= S_IDLE;
					end else begin
						flow_q  <= bal_t_q;
						state_q <= S_BFS_INIT;
					end
				end

				// new breadth-first round from the source
				S_BFS_INIT: begin
					vis_q       <= {{(MAX_NODES-1){1'b0}}, 1'b1} << s_i;
					head_q      <= '0;
					tail_q      <= CW'(1);
					state_q     <= S_DEQ;
				end

				S_DEQ: begin
					if (head_q == tail_q) begin
						state_q <= S_RUN_DONE;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= S_POP;
					end
				end

				S_POP: begin
					i_q     <= q_rd;
					state_q <= S_LDB;
				end

				S_LDB: begin
					bi_q       <= bn_rd;
					j_q        <= '0;
					iss_done_q <= 1'b0;
					scan_v_s1  <= 1'b0;
					state_q    <= S_SCAN;
				end

				// scan the row of the dequeued node in ascending order
				S_SCAN: begin
					if (!iss_done_q) begin
						scan_v_s1    <= !found;
						scan_j_s1    <= j_q;
						scan_last_s1 <= j_last;
						j_q          <= j_q + 1'b1;
						if (j_last) begin
							iss_done_q <= 1'b1;
						end
					end else begin
						scan_v_s1 <= 1'b0;
					end
					if (hit) begin
						vis_q[scan_j_s1] <= 1'b1;
						if (!found) begin
							tail_q <= tail_q + 1'b1;
						end
					end
					if (found) begin
						aug_b_q   <= nb;
						flow_q    <= flow_q + $signed(BW'(nb));
						cur_q     <= t_i;
						state_q   <= S_AUG_P;
					end else if (scan_v_s1 && scan_last_s1) begin
						state_q <= S_DEQ;
					end
				end

				// walk the path back from the sink
				S_AUG_P: begin
					state_q <= S_AUG_R;
				end

				S_AUG_R: begin
					prev_q  <= par_rd;
					state_q <= S_AUG_W1;
				end

				S_AUG_W1: begin
					rb_q    <= rd_b_res;
					state_q <= S_AUG_W2;
				end

				S_AUG_W2: begin
					cur_q   <= prev_q;
					state_q <= (prev_q == s_i) ? S_BFS_INIT : S_AUG_P;
				end

				S_RUN_DONE: begin
					err_q   <= ST_OK;
					state_q <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// no request beat is taken during the clearing pass
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> !req.ready)
		else $error("request taken during clearing pass");

	// a good run status cannot coexist with a rejected load
	a_ok_not_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q == ST_OK) |-> !rej_q)
		else $error("status ok while a load is rejected");

	// a response appears only from a taken beat or finished work
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(accept) || ($past(state_q) != S_IDLE)))
		else $error("response beat without cause");

	// the two words of a path edge are distinct
	a_aug_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AUG_W2) |-> (prev_q != cur_q))
		else $error("augment on a self pair");

endmodule
`default_nettype wire

// ===== bench/tb_max_flow_min_cut_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_flow_min_cut_engine: self-checking bench of the max-flow engine
// Runs a short table of directed requests, then random rounds of edge loads,
// runs and queries under several configurations. It checks every field of
// each response beat against its own Edmonds-Karp model or a typed row.
// ----------------------------------------------------------------------------
module tb_max_flow_min_cut_engine;
	import mfmc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int NODES = MAX_NODES_DEF;
	localparam int NO_PARENT = -1;

	typedef struct packed {
		func_t               fn;
		logic [NODE_W-1:0]   x;
		logic [NODE_W-1:0]   y;
		logic [CAP_IN_W-1:0] cap;
		logic [CAP_IN_W-1:0] fin;
	} flow_req_t;

	typedef struct packed {
		status_t            st;
		logic [VALUE_W-1:0] val;
		logic               ex;
		logic               cut;
	} flow_rsp_t;

	typedef struct {
		flow_req_t rq;
		bit        typed;
		flow_rsp_t rs;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SOURCE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	mfmc_req_if req_ch();
	mfmc_rsp_if rsp_ch();

	max_flow_min_cut_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #6 clk = ~clk;

	// graph mirror
	int resid_cap [NODES][NODES];
	int orig_cap [NODES][NODES];
	bit edge_loaded [NODES][NODES];
	int bfs_parent [NODES];
	int bfs_queue [NODES];
	int bfs_bottleneck [NODES];
	logic [VALUE_W-1:0] flow_total;
	status_t run_status;
	bit load_refused;
	logic [NODE_W-1:0] cur_source;
	logic [NODE_W-1:0] cur_sink;
	logic [NCOUNT_W-1:0] cur_count;

	flow_rsp_t pending_rsp [$];
	plan_row_t plan [$];
	int errors = 0;
	int items = 0;
	int snd_pct = 8;
	int rcv_pct = 77;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	function automatic int active_n();
		return (cur_count < NODES) ? int'(cur_count) : NODES;
	endfunction

	function automatic void clear_graph();
		for (int i = 0; i < NODES; i++) begin
			bfs_parent[i] = NO_PARENT;
			for (int j = 0; j < NODES; j++) begin
				resid_cap[i][j] = 0;
				orig_cap[i][j] = 0;
				edge_loaded[i][j] = 1'b0;
			end
		end
		flow_total = '0;
		run_status = ST_NOT_RUN;
		load_refused = 1'b0;
	endfunction

	// breadth-first search in ascending neighbour order, returns bottleneck
	function automatic int find_path(int n, int s, int t);
		int hd, tl, i, r, b;
		hd = 0;
		tl = 0;
		for (int k = 0; k < NODES; k++) bfs_parent[k] = NO_PARENT;
		bfs_parent[s] = s;
		bfs_bottleneck[s] = 65535;
		bfs_queue[tl] = s;
		tl++;
		while (hd < tl) begin
			i = bfs_queue[hd];
			hd++;
			for (int j = 0; j < n; j++) begin
				r = resid_cap[i][j];
				if (bfs_parent[j] == NO_PARENT && r != 0) begin
					b = (bfs_bottleneck[i] < r) ? bfs_bottleneck[i] : r;
					bfs_parent[j] = i;
					bfs_bottleneck[j] = b;
					if (j == t) return b;
					if (tl < NODES) begin
						bfs_queue[tl] = j;
						tl++;
					end
				end
			end
		end
		return 0;
	endfunction

	function automatic status_t run_graph();
		longint bal [NODES];
		longint f, flow;
		int n, s, t, b, cur, prv;
		n = active_n();
		s = int'(cur_source);
		t = int'(cur_sink);
		flow_total = '0;
		for (int k = 0; k < NODES; k++) bfs_parent[k] = NO_PARENT;
		if (load_refused) return ST_OVER_CAP;
		if (s >= n || t >= n) return ST_CONSERVE;
		for (int k = 0; k < NODES; k++) bal[k] = 0;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (edge_loaded[i][j]) begin
					f = longint'(orig_cap[i][j]) - longint'(resid_cap[i][j]);
					bal[i] -= f;
					bal[j] += f;
				end
		for (int i = 0; i < n; i++)
			if (i != s && i != t && bal[i] != 0) return ST_CONSERVE;
		if (bal[s] != -bal[t]) return ST_CONSERVE;
		flow = bal[t];
		b = find_path(n, s, t);
		while (b != 0) begin
			flow += b;
			cur = t;
			while (cur != s) begin
				prv = bfs_parent[cur];
				resid_cap[prv][cur] -= b;
				resid_cap[cur][prv] += b;
				cur = prv;
			end
			b = find_path(n, s, t);
		end
		if (flow < 0) flow = 0;
		if (flow > longint'(VALUE_MAX)) flow = longint'(VALUE_MAX);
		flow_total = flow[VALUE_W-1:0];
		return ST_OK;
	endfunction

	// expected response of one request, updating the mirror
	function automatic flow_rsp_t predict_rsp(flow_req_t q);
		flow_rsp_t o;
		int n, x, y, f;
		o.st = run_status;
		o.val = '0;
		o.ex = 1'b0;
		o.cut = 1'b0;
		n = active_n();
		x = int'(q.x);
		y = int'(q.y);
		case (q.fn)
			FN_LOAD: begin
				if (x < n && y < n && x != y) begin
					run_status = ST_NOT_RUN;
					if (q.fin > q.cap) begin
						load_refused = 1'b1;
						o.st = ST_OVER_CAP;
					end else begin
						resid_cap[x][y] = int'(q.cap) - int'(q.fin);
						resid_cap[y][x] = int'(q.fin);
						orig_cap[x][y] = int'(q.cap);
						orig_cap[y][x] = 0;
						edge_loaded[x][y] = 1'b1;
						edge_loaded[y][x] = 1'b0;
						o.st = ST_NOT_RUN;
					end
				end
			end
			FN_RUN: begin
				run_status = run_graph();
				o.st = run_status;
				o.val = flow_total;
			end
			FN_QUERY: begin
				if (edge_loaded[x][y]) begin
					f = orig_cap[x][y] - resid_cap[x][y];
					o.ex = 1'b1;
					o.val = VALUE_W'(f);
					if (run_status == ST_OK && bfs_parent[x] != NO_PARENT &&
							bfs_parent[y] == NO_PARENT)
						o.cut = 1'b1;
				end
			end
			default: begin
				clear_graph();
				o.st = ST_NOT_RUN;
			end
		endcase
		return o;
	endfunction

	// response side: checking, random stalls and long hold-offs
	always @(posedge clk) begin
		flow_rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat st=%0d val=%0d ex=%0d cut=%0d", $time,
					rsp_ch.status, rsp_ch.value, rsp_ch.edge_exists, rsp_ch.in_cut);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.status !== want.st) begin
					errors++;
					$display("%0t: status expected %0d got %0d", $time, want.st,
						rsp_ch.status);
				end
				if (rsp_ch.value !== want.val) begin
					errors++;
					$display("%0t: value expected %0d got %0d", $time, want.val,
						rsp_ch.value);
				end
				if (rsp_ch.edge_exists !== want.ex) begin
					errors++;
					$display("%0t: edge_exists expected %0d got %0d", $time, want.ex,
						rsp_ch.edge_exists);
				end
				if (rsp_ch.in_cut !== want.cut) begin
					errors++;
					$display("%0t: in_cut expected %0d got %0d", $time, want.cut,
						rsp_ch.in_cut);
				end
			end
		end
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= 600;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_pct);
		end
	end

	// offer one request beat; valid stays high after acceptance
	task automatic send_req(flow_req_t q, bit typed, flow_rsp_t rs);
		flow_rsp_t got;
		while ($urandom_range(0, 99) < snd_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= q.fn;
		req_ch.tail_node <= q.x;
		req_ch.head_node <= q.y;
		req_ch.edge_capacity_in <= q.cap;
		req_ch.edge_flow_in <= q.fin;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		got = predict_rsp(q);
		pending_rsp = {pending_rsp, (typed ? rs : got)};
		items++;
		if (items == 200) begin
			snd_pct = 77;
			rcv_pct = 8;
		end else if (items == 400) begin
			snd_pct = 0;
			rcv_pct = 0;
		end
	endtask

	task automatic send_plain(func_t fn, int x, int y, int cap, int fin);
		flow_req_t q;
		q.fn = fn;
		q.x = NODE_W'(x);
		q.y = NODE_W'(y);
		q.cap = CAP_IN_W'(cap);
		q.fin = CAP_IN_W'(fin);
		send_req(q, 1'b0, '0);
	endtask

	// wait until every response is back and the block is idle
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_SOURCE: cur_source = d[NODE_W-1:0];
			REG_SINK:   cur_sink = d[NODE_W-1:0];
			REG_NODES:  cur_count = d;
			default:    ;
		endcase
	endtask

	task automatic set_config(int src, int snk, int cnt);
		drain();
		write_reg(REG_NODES, CFG_DATA_W'(cnt));
		write_reg(REG_SOURCE, CFG_DATA_W'(src));
		write_reg(REG_SINK, CFG_DATA_W'(snk));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 127)));
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_row(func_t fn, int x, int y, int cap, int fin, bit typed,
			status_t st, int val);
		plan_row_t r;
		r.rq.fn = fn;
		r.rq.x = NODE_W'(x);
		r.rq.y = NODE_W'(y);
		r.rq.cap = CAP_IN_W'(cap);
		r.rq.fin = CAP_IN_W'(fin);
		r.typed = typed;
		r.rs.st = st;
		r.rs.val = VALUE_W'(val);
		r.rs.ex = 1'b0;
		r.rs.cut = 1'b0;
		plan = {plan, r};
	endtask

	function automatic int pick_cap();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) return $urandom_range(1, 20);
		if (sel < 8) return $urandom_range(0, 65535);
		return (sel == 8) ? 65535 : 0;
	endfunction

	// one random round: configure, maybe clear, load, run, query
	task automatic random_round(int forced_cnt);
		int n, cnt, s, t, loads, a, cap, fin, sel, qn, x, y;
		sel = $urandom_range(0, 9);
		if (forced_cnt != 0) cnt = forced_cnt;
		else if (sel == 0) cnt = ($urandom_range(0, 1) != 0) ? 64 : $urandom_range(65, 127);
		else if (sel == 1) cnt = $urandom_range(1, 3);
		else cnt = $urandom_range(4, 12);
		n = (cnt < NODES) ? cnt : NODES;
		s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
		t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
		set_config(s | ($urandom_range(0, 1) << NODE_W), t, cnt);
		if ($urandom_range(0, 2) == 0) send_plain(FN_CLEAR, $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom, $urandom);
		if (hold_asks == 0 && items >= 420) hold_asks++;
		loads = (n == NODES) ? 24 : $urandom_range(2, 2 * n + 2);
		for (int k = 0; k < loads; k++) begin
			cap = pick_cap();
			sel = $urandom_range(0, 99);
			if (sel < 80) fin = 0;
			else if (sel < 90) fin = $urandom_range(0, cap);
			else if (sel < 97) fin = cap;
			else fin = (cap < 65535) ? $urandom_range(cap + 1, 65535) : cap;
			if ($urandom_range(0, 19) == 0) begin
				x = $urandom_range(0, 63);
				y = $urandom_range(0, 63);
			end else begin
				x = $urandom_range(0, n - 1);
				y = $urandom_range(0, n - 1);
			end
			send_plain(FN_LOAD, x, y, cap, fin);
		end
		// a path that carries a consistent initial flow, either direction
		if (n >= 3 && s < n && t < n && s != t && $urandom_range(0, 2) == 0) begin
			a = $urandom_range(0, n - 1);
			if (a != s && a != t) begin
				cap = $urandom_range(1, 65535);
				fin = $urandom_range(0, cap);
				if ($urandom_range(0, 1) != 0) begin
					send_plain(FN_LOAD, s, a, cap, fin);
					send_plain(FN_LOAD, a, t, $urandom_range(fin, 65535), fin);
				end else begin
					send_plain(FN_LOAD, t, a, cap, fin);
					send_plain(FN_LOAD, a, s, $urandom_range(fin, 65535), fin);
				end
			end
		end
		if ($urandom_range(0, 9) == 0) drain();
		send_plain(FN_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, $urandom);
		qn = $urandom_range(2, 8);
		for (int k = 0; k < qn; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				x = $urandom_range(0, 63);
				y = $urandom_range(0, 63);
			end else begin
				x = $urandom_range(0, n - 1);
				y = $urandom_range(0, n - 1);
			end
			send_plain(FN_QUERY, x, y, $urandom, $urandom);
		end
	endtask

	// run limit
	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int round;
		req_ch.valid = 1'b0;
		req_ch.func = FN_LOAD;
		req_ch.tail_node = '0;
		req_ch.head_node = '0;
		req_ch.edge_capacity_in = '0;
		req_ch.edge_flow_in = '0;
		rsp_ch.ready = 1'b0;
		cur_source = SRC_RESET;
		cur_sink = SNK_RESET;
		cur_count = NCOUNT_RESET;
		clear_graph();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset configuration
		add_row(FN_QUERY, 0, 1, 0, 0, 1, ST_NOT_RUN, 0);
		add_row(FN_RUN, 0, 0, 0, 0, 1, ST_OK, 0);
		add_row(FN_LOAD, 0, 1, 65535, 0, 1, ST_NOT_RUN, 0);
		add_row(FN_LOAD, 0, 2, 7, 0, 0, ST_OK, 0);
		add_row(FN_LOAD, 2, 1, 3, 0, 0, ST_OK, 0);
		add_row(FN_LOAD, 63, 62, 65535, 65535, 0, ST_OK, 0);
		add_row(FN_LOAD, 62, 63, 1, 0, 0, ST_OK, 0);
		add_row(FN_LOAD, 5, 5, 3, 0, 1, ST_NOT_RUN, 0);
		add_row(FN_RUN, 63, 63, 65535, 65535, 0, ST_OK, 0);
		add_row(FN_QUERY, 0, 1, 0, 0, 0, ST_OK, 0);
		add_row(FN_QUERY, 2, 1, 0, 0, 0, ST_OK, 0);
		add_row(FN_QUERY, 62, 63, 0, 0, 0, ST_OK, 0);
		add_row(FN_QUERY, 63, 62, 0, 0, 0, ST_OK, 0);
		add_row(FN_QUERY, 63, 63, 65535, 65535, 0, ST_OK, 0);
		add_row(FN_LOAD, 3, 4, 0, 0, 0, ST_OK, 0);
		add_row(FN_LOAD, 3, 4, 9, 10, 1, ST_OVER_CAP, 0);
		add_row(FN_RUN, 0, 0, 0, 0, 1, ST_OVER_CAP, 0);
		add_row(FN_QUERY, 0, 1, 0, 0, 0, ST_OK, 0);
		add_row(FN_CLEAR, 0, 0, 0, 0, 1, ST_NOT_RUN, 0);
		add_row(FN_LOAD, 1, 0, 10, 4, 0, ST_OK, 0);
		add_row(FN_RUN, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(FN_QUERY, 1, 0, 0, 0, 0, ST_OK, 0);
		add_row(FN_LOAD, 4, 6, 5, 5, 0, ST_OK, 0);
		add_row(FN_RUN, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(FN_CLEAR, 63, 63, 65535, 65535, 1, ST_NOT_RUN, 0);
		foreach (plan[i]) send_req(plan[i].rq, plan[i].typed, plan[i].rs);

		// random rounds, the node count extremes first
		round = 0;
		while (items < 600) begin
			random_round(round == 0 ? 1 : round == 1 ? 127 : round == 2 ? 64 : 0);
			round++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
